FILE: rtl/qes_pkg.sv
// Shared types and constants for the quadrature encoder speed block.
// Holds the transaction payload structs, register indexes and fixed widths.
// No dependencies.
package qes_pkg;

   localparam int VEL_W        = 16;
   localparam int POSITION_W   = 16;
   localparam int RPM_W        = 24;
   localparam int FILT_W       = 24;
   localparam int COUNT_W      = 16;
   localparam int ALPHA_W      = 9;

   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_RELOAD  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ALPHA = 1'd1;

   localparam logic [COUNT_W-1:0] AUTO_RELOAD_RESET  = 16'hFFFF;
   localparam logic [ALPHA_W-1:0] FILTER_ALPHA_RESET = 9'd26;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE          = 9'd256;

   // Milliseconds per second times seconds per minute.
   localparam int MS_PER_SECOND      = 1000;
   localparam int SECONDS_PER_MINUTE = 60;
   localparam int RPM_NUMERATOR      = MS_PER_SECOND * SECONDS_PER_MINUTE;

   // Magnitude of the most negative velocity.
   localparam int VEL_LIMIT = 2 ** (VEL_W - 1);

   typedef struct packed {
      logic [COUNT_W-1:0] counter_value;
      logic               count_down;
   } req_type;

   typedef struct packed {
      logic signed [VEL_W-1:0]  velocity;
      logic [POSITION_W-1:0]    position;
      logic signed [RPM_W-1:0]  rpm;
      logic signed [FILT_W-1:0] velocity_filtered;
   } rsp_type;

endpackage

FILE: rtl/quadrature_encoder_speed.sv
// Top level of the quadrature encoder speed block: velocity, position, RPM and
// IIR-filtered velocity from sampled encoder timer counts.
// Depends on qes_pkg.

// Usage:
// Each transaction on the req channel carries one sampling tick: the encoder
// timer count and the timer direction. For every request transaction the block
// returns exactly one transaction on the rsp channel with the signed count
// change (velocity), the shaft position modulo PULSES_PER_REV, the RPM and the
// filtered velocity in Q.8.
// An accepted request moves through the stage registers in order and then
// shows up as rsp_valid. Throughput is one transaction per cycle while the
// result side does not stall. The pipeline has five registered stages
// (input, velocity, divide-by-constant products, RPM and filter, position
// and output), each holding one transaction.
// When the receiver stalls, the output holds and stages behind it keep filling
// bubbles, so requests are still taken until all five stages are occupied.
// Reset clears all valid bits, the previous count, the position and the filter
// state, and returns auto_reload and filter_alpha to their defaults.
// The user writes csr only while no transaction is in flight; it is not enforced.
module quadrature_encoder_speed #(
   parameter int PULSES_PER_REV   = 1024,
   parameter int SAMPLE_PERIOD_MS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  qes_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output qes_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write,
   input  logic [qes_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [qes_pkg::CSR_DATA_W-1:0]     csr_data
);
   import qes_pkg::*;

   // Position is kept as a residue below PULSES_PER_REV.
   localparam int POS_W = $clog2(PULSES_PER_REV);

   // Position reduction: the velocity plus a multiple of PULSES_PER_REV is
   // non-negative and below 2^17, and its quotient comes from an exact
   // reciprocal multiply.
   localparam int MOD_X_W    = VEL_W + 1;
   localparam int MOD_SHIFT  = MOD_X_W + POS_W;
   localparam int MOD_MULT_W = MOD_X_W + 2;
   localparam int MOD_PROD_W = MOD_X_W + MOD_MULT_W;
   localparam int MOD_OFFSET_I =
      PULSES_PER_REV * ((VEL_LIMIT + PULSES_PER_REV - 1) / PULSES_PER_REV);
   localparam logic [MOD_X_W-1:0]    MOD_OFFSET = MOD_X_W'(MOD_OFFSET_I);
   localparam logic [MOD_MULT_W-1:0] MOD_MULT   =
      MOD_MULT_W'(((longint'(1) << MOD_SHIFT) + PULSES_PER_REV - 1) / PULSES_PER_REV);
   localparam logic [MOD_X_W-1:0]    PPR_X      = MOD_X_W'(PULSES_PER_REV);
   localparam logic [POS_W:0]        PPR_SUM    = (POS_W + 1)'(PULSES_PER_REV);

   // RPM: |velocity| * 60000 / (period * PPR) as one exact reciprocal multiply.
   localparam int RPM_DIV    = SAMPLE_PERIOD_MS * PULSES_PER_REV;
   localparam int RPM_SHIFT  = (VEL_W - 1) + $clog2(RPM_DIV);
   localparam int RPM_MULT_W = 32;
   localparam int RPM_PROD_W = VEL_W + RPM_MULT_W;
   localparam int RPM_MAG_W  = 32;
   localparam logic [RPM_MULT_W-1:0] RPM_MULT =
      RPM_MULT_W'(((longint'(RPM_NUMERATOR) << RPM_SHIFT) + RPM_DIV - 1) / RPM_DIV);
   localparam logic [RPM_MAG_W-1:0] RPM_POS_MAX = RPM_MAG_W'(2 ** (RPM_W - 1) - 1);
   localparam logic [RPM_MAG_W-1:0] RPM_NEG_MAX = RPM_MAG_W'(2 ** (RPM_W - 1));

   // Velocity difference before saturation is held in 19 signed bits.
   localparam int RAW_W = COUNT_W + 3;
   localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'(2 ** (VEL_W - 1) - 1);
   localparam logic signed [RAW_W-1:0] RAW_MIN = -RAW_W'(VEL_LIMIT);

   // Filter arithmetic widths.
   localparam int DIFF_W  = FILT_W + 2;
   localparam int FPROD_W = DIFF_W + ALPHA_W + 1;
   localparam int FSUM_W  = FILT_W + 4;
   localparam logic signed [FSUM_W-1:0] FILT_MAX = FSUM_W'(2 ** (FILT_W - 1) - 1);
   localparam logic signed [FSUM_W-1:0] FILT_MIN = -FSUM_W'(2 ** (FILT_W - 1));

   // Configuration registers.
   logic [COUNT_W-1:0] auto_reload_ff;
   logic [ALPHA_W-1:0] filter_alpha_ff;

   // Block state.
   logic [COUNT_W-1:0]       prev_count_ff;
   logic [POS_W-1:0]         shaft_ff;
   logic signed [FILT_W-1:0] filt_ff;

   // Stage valid bits and stage enables.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5;

   // Stage payloads.
   req_type                   s1_req_ff;
   logic signed [VEL_W-1:0]   s2_vel_ff, s2_vel_in;
   logic signed [VEL_W-1:0]   s3_vel_ff;
   logic [MOD_X_W-1:0]        s3_modx_ff, s3_modx_in;
   logic [MOD_X_W-1:0]        s3_quot_ff, s3_quot_in;
   logic [RPM_PROD_W-1:0]     s3_rpm_prod_ff, s3_rpm_prod_in;
   logic signed [VEL_W-1:0]   s4_vel_ff;
   logic [POS_W-1:0]          s4_vmod_ff, s4_vmod_in;
   logic signed [RPM_W-1:0]   s4_rpm_ff, s4_rpm_in;
   logic signed [FILT_W-1:0]  filt_in;
   logic [POS_W-1:0]          shaft_in;
   rsp_type                   rsp_ff, rsp_in;

   // Stage 2 working signals.
   logic signed [RAW_W-1:0] cnt_x, last_x, period_x, raw_delta;
   logic [COUNT_W:0]        period_u;

   // Stage 3 working signals.
   logic [MOD_PROD_W-1:0]   mod_prod;
   logic [VEL_W-1:0]        vel_abs;

   // Stage 4 working signals.
   logic [MOD_X_W-1:0]       mod_rem;
   logic [RPM_MAG_W-1:0]     rpm_mag;
   logic [ALPHA_W-1:0]       alpha_eff;
   logic signed [DIFF_W-1:0] filt_diff;
   logic signed [FPROD_W-1:0] filt_prod;
   logic signed [FPROD_W-1:0] filt_round;
   logic signed [FSUM_W-1:0] filt_step;
   logic signed [FSUM_W-1:0] filt_sum;

   // Stage 5 working signals.
   logic [POS_W:0] pos_sum;

   // A stage may load when it is empty or its transaction moves on.
   always_comb begin
      en5 = !rsp_valid_ff || !rsp_stall;
      en4 = !s4_valid_ff || en5;
      en3 = !s3_valid_ff || en4;
      en2 = !s2_valid_ff || en3;
      en1 = !s1_valid_ff || en2;
   end

   assign req_stall = !en1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Stage 2: signed count change. A change whose sign disagrees with the
   // direction is a wrap through the counter period.
   always_comb begin
      period_u = {1'b0, auto_reload_ff} + (COUNT_W + 1)'(1);
      cnt_x    = $signed({3'b000, s1_req_ff.counter_value});
      last_x   = $signed({3'b000, prev_count_ff});
      period_x = $signed({2'b00, period_u});
      priority if (s1_req_ff.counter_value == prev_count_ff) begin
         raw_delta = '0;
      end else if (s1_req_ff.counter_value > prev_count_ff) begin
         raw_delta = s1_req_ff.count_down ? -(last_x + period_x - cnt_x) : cnt_x - last_x;
      end else begin
         raw_delta = s1_req_ff.count_down ? cnt_x - last_x : cnt_x + period_x - last_x;
      end
      priority if (raw_delta > RAW_MAX) begin
         s2_vel_in = RAW_MAX[VEL_W-1:0];
      end else if (raw_delta < RAW_MIN) begin
         s2_vel_in = RAW_MIN[VEL_W-1:0];
      end else begin
         s2_vel_in = raw_delta[VEL_W-1:0];
      end
   end

   // Stage 3: reciprocal products for the position residue and for the RPM.
   always_comb begin
      s3_modx_in = MOD_OFFSET + {{(MOD_X_W - VEL_W){s2_vel_ff[VEL_W-1]}}, s2_vel_ff};
      mod_prod   = MOD_PROD_W'(s3_modx_in) * MOD_PROD_W'(MOD_MULT);
      s3_quot_in = MOD_X_W'(mod_prod >> MOD_SHIFT);
      vel_abs    = s2_vel_ff[VEL_W-1] ? (~s2_vel_ff + VEL_W'(1)) : s2_vel_ff;
      s3_rpm_prod_in = RPM_PROD_W'(vel_abs) * RPM_PROD_W'(RPM_MULT);
   end

   // Stage 4: velocity residue, saturated RPM and one filter step.
   always_comb begin
      mod_rem    = s3_modx_ff - MOD_X_W'(s3_quot_ff * PPR_X);
      s4_vmod_in = mod_rem[POS_W-1:0];

      // Truncation toward zero works on the magnitude.
      rpm_mag = RPM_MAG_W'(s3_rpm_prod_ff >> RPM_SHIFT);
      if (s3_vel_ff[VEL_W-1]) begin
         s4_rpm_in = (rpm_mag > RPM_NEG_MAX) ? -RPM_W'(RPM_NEG_MAX) : -RPM_W'(rpm_mag);
      end else begin
         s4_rpm_in = (rpm_mag > RPM_POS_MAX) ? RPM_W'(RPM_POS_MAX) : RPM_W'(rpm_mag);
      end

      // f += floor((alpha * (v*256 - f) + 128) / 256), saturated.
      alpha_eff  = (filter_alpha_ff > ALPHA_ONE) ? ALPHA_ONE : filter_alpha_ff;
      filt_diff  = $signed({{2{s3_vel_ff[VEL_W-1]}}, s3_vel_ff, 8'h00})
                 - $signed({{2{filt_ff[FILT_W-1]}}, filt_ff});
      filt_prod  = $signed({1'b0, alpha_eff}) * filt_diff;
      filt_round = filt_prod + FPROD_W'(128);
      filt_step  = FSUM_W'(filt_round >>> 8);
      filt_sum   = $signed({{(FSUM_W - FILT_W){filt_ff[FILT_W-1]}}, filt_ff}) + filt_step;
      priority if (filt_sum > FILT_MAX) begin
         filt_in = FILT_MAX[FILT_W-1:0];
      end else if (filt_sum < FILT_MIN) begin
         filt_in = FILT_MIN[FILT_W-1:0];
      end else begin
         filt_in = filt_sum[FILT_W-1:0];
      end
   end

   // Stage 5: position accumulate with a single wrap, and result assembly.
   always_comb begin
      pos_sum  = {1'b0, shaft_ff} + {1'b0, s4_vmod_ff};
      shaft_in = (pos_sum >= PPR_SUM) ? POS_W'(pos_sum - PPR_SUM) : pos_sum[POS_W-1:0];
      rsp_in.velocity          = s4_vel_ff;
      rsp_in.position          = POSITION_W'(shaft_in);
      rsp_in.rpm               = s4_rpm_ff;
      rsp_in.velocity_filtered = filt_ff;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         auto_reload_ff  <= AUTO_RELOAD_RESET;
         filter_alpha_ff <= FILTER_ALPHA_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AUTO_RELOAD: begin
               auto_reload_ff <= csr_data;
            end
            CSR_FILTER_ALPHA: begin
               filter_alpha_ff <= csr_data[ALPHA_W-1:0];
            end
         endcase
      end
   end

   // Valid bits and the state that carries from one transaction to the next.
   // Each piece of state is updated by the stage that consumes it, so
   // transactions see it in order.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         prev_count_ff <= '0;
         shaft_ff      <= '0;
         filt_ff       <= '0;
      end else begin
         if (en1) begin
            s1_valid_ff <= req_valid;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (en3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (en4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (en5) begin
            rsp_valid_ff <= s4_valid_ff;
         end
         if (en2 && s1_valid_ff) begin
            prev_count_ff <= s1_req_ff.counter_value;
         end
         if (en4 && s3_valid_ff) begin
            filt_ff <= filt_in;
         end
         if (en5 && s4_valid_ff) begin
            shaft_ff <= shaft_in;
         end
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (en1 && req_valid) begin
         s1_req_ff <= req_data;
      end
      if (en2 && s1_valid_ff) begin
         s2_vel_ff <= s2_vel_in;
      end
      if (en3 && s2_valid_ff) begin
         s3_vel_ff      <= s2_vel_ff;
         s3_modx_ff     <= s3_modx_in;
         s3_quot_ff     <= s3_quot_in;
         s3_rpm_prod_ff <= s3_rpm_prod_in;
      end
      if (en4 && s3_valid_ff) begin
         s4_vel_ff  <= s3_vel_ff;
         s4_vmod_ff <= s4_vmod_in;
         s4_rpm_ff  <= s4_rpm_in;
      end
      if (en5 && s4_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: rtl/qes_checker.sv
// Port-level checks for the quadrature encoder speed block, bound to its top.
// Tracks transactions in flight from the handshakes. Depends on qes_pkg.
module qes_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input qes_pkg::rsp_type rsp_data
);
   import qes_pkg::*;

   // The block holds at most one transaction in each of its five stages.
   localparam logic [2:0] PIPE_DEPTH = 3'd5;

   logic [2:0] outstanding_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 3'(req_take) - 3'(rsp_take);
      end
   end

   a_reset_clears_output: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 3'd0)
      else $error("result offered with no request in flight");

   a_depth_bounded: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= PIPE_DEPTH)
      else $error("more transactions in flight than pipeline stages");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff == 3'd0 |-> !req_stall)
      else $error("request stalled while block is empty");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed or was dropped");

endmodule

bind quadrature_encoder_speed qes_checker u_qes_checker (.*);

FILE: tb/quadrature_encoder_speed_test.sv
// Self-checking testbench for quadrature_encoder_speed: drives sampled timer counts,
// predicts velocity, position, RPM and filtered velocity, and compares every result.
// Depends on qes_pkg and the quadrature_encoder_speed RTL.
module quadrature_encoder_speed_test;
   timeunit 1ns;
   timeprecision 1ps;

   import qes_pkg::*;

   localparam int PULSES_PER_REV   = 1024;
   localparam int SAMPLE_PERIOD_MS = 10;
   localparam int LATENCY          = 4;
   localparam int HOLD_CYCLES      = 60;
   localparam int CYCLE_LIMIT      = 200000;

   // Hand-picked ticks, run under the reset register values: equal counts, single
   // steps both ways, wraps in both directions, a position that goes below zero,
   // and raw changes outside the signed 16-bit range that must saturate at both ends.
   localparam logic [16:0] DIRECTED_TICKS [16] = '{
      {16'd0, 1'b0}, {16'd1, 1'b0}, {16'd0, 1'b1}, {16'hFFFF, 1'b1},
      {16'd0, 1'b0}, {16'd32767, 1'b0}, {16'd0, 1'b1}, {16'd40000, 1'b0},
      {16'd0, 1'b1}, {16'hFFFF, 1'b0}, {16'd1, 1'b0}, {16'hFFFF, 1'b0},
      {16'd0, 1'b1}, {16'd100, 1'b1}, {16'd50, 1'b0}, {16'd50, 1'b1}
   };

   // Tracks the encoder state the block should hold and keeps the readings that
   // accepted ticks have not yet produced.
   class encoder_tracker;
      logic [COUNT_W-1:0]       auto_reload;
      logic [ALPHA_W-1:0]       filter_alpha;
      logic [COUNT_W-1:0]       previous_count;
      logic [POSITION_W-1:0]    shaft_position;
      logic signed [FILT_W-1:0] filter_value;
      rsp_type                  pending_readings[$];
      int                       errors;

      function new();
         auto_reload    = AUTO_RELOAD_RESET;
         filter_alpha   = FILTER_ALPHA_RESET;
         previous_count = '0;
         shaft_position = '0;
         filter_value   = '0;
         errors         = 0;
      endfunction

      function longint clamp(longint x, longint lo, longint hi);
         if (x < lo) return lo;
         if (x > hi) return hi;
         return x;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] index,
                                   logic [CSR_DATA_W-1:0] data);
         if (index == CSR_AUTO_RELOAD) begin
            auto_reload = data[COUNT_W-1:0];
         end else if (index == CSR_FILTER_ALPHA) begin
            filter_alpha = data[ALPHA_W-1:0];
         end
      endfunction

      function void note_tick(req_type tick);
         longint count;
         longint last;
         longint period;
         longint raw;
         longint vel;
         longint pos;
         longint rpm;
         longint alpha;
         longint f;
         rsp_type reading;
         count  = longint'(tick.counter_value);
         last   = longint'(previous_count);
         period = longint'(auto_reload) + 1;
         // A change whose sign disagrees with the direction means the timer wrapped.
         if (count == last) begin
            raw = 0;
         end else if (count > last) begin
            raw = tick.count_down ? -(last + period - count) : count - last;
         end else begin
            raw = tick.count_down ? count - last : count + period - last;
         end
         vel = clamp(raw, -32768, 32767);
         pos = (longint'(shaft_position) + vel) % PULSES_PER_REV;
         if (pos < 0) pos += PULSES_PER_REV;
         shaft_position = pos[POSITION_W-1:0];
         rpm = (vel * RPM_NUMERATOR) / longint'(SAMPLE_PERIOD_MS * PULSES_PER_REV);
         rpm = clamp(rpm, -8388608, 8388607);
         alpha = (filter_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(filter_alpha);
         f = longint'(filter_value);
         // Arithmetic shift of a signed value rounds toward minus infinity.
         f = f + ((alpha * (vel * 256 - f) + 128) >>> 8);
         f = clamp(f, -8388608, 8388607);
         filter_value   = f[FILT_W-1:0];
         previous_count = tick.counter_value;
         reading.velocity          = vel[VEL_W-1:0];
         reading.position          = pos[POSITION_W-1:0];
         reading.rpm               = rpm[RPM_W-1:0];
         reading.velocity_filtered = f[FILT_W-1:0];
         pending_readings.push_back(reading);
      endfunction

      function void check_reading(rsp_type got);
         rsp_type want;
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected reading, expected none, actual vel %0d pos %0d",
                     $time, got.velocity, got.position);
            errors++;
            return;
         end
         want = pending_readings.pop_front();
         if (got.velocity !== want.velocity) begin
            $display("%0t: velocity expected %0d actual %0d",
                     $time, want.velocity, got.velocity);
            errors++;
         end
         if (got.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d",
                     $time, want.position, got.position);
            errors++;
         end
         if (got.rpm !== want.rpm) begin
            $display("%0t: rpm expected %0d actual %0d", $time, want.rpm, got.rpm);
            errors++;
         end
         if (got.velocity_filtered !== want.velocity_filtered) begin
            $display("%0t: velocity_filtered expected %0d actual %0d",
                     $time, want.velocity_filtered, got.velocity_filtered);
            errors++;
         end
      endfunction

      function int pending();
         return pending_readings.size();
      endfunction
   endclass

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   encoder_tracker tracker = new();

   // Stimulus control shared between the sender and the receiver processes.
   bit     gaps_on   = 1'b0;
   bit     long_hold = 1'b0;
   int     cycle_count = 0;
   longint enc_pos = 0;
   longint cur_period = 65536;
   bit     moving_down = 1'b0;

   quadrature_encoder_speed #(
      .PULSES_PER_REV   (PULSES_PER_REV),
      .SAMPLE_PERIOD_MS (SAMPLE_PERIOD_MS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Watchdog: a hang or a lost transaction ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Every result transaction is checked at the edge that accepts it. Values are
   // read before the edge's updates land, so the sampling is free of races.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_reading(rsp_data);
      end
   end

   // Receiver side. A long hold, when requested, keeps the output stalled so the
   // pipeline fills and pushes back on the sender. Otherwise short random stalls
   // appear while gaps are enabled.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offers one tick and waits until the block takes it. The payload holds while
   // stalled. A random gap may follow, except during a long hold, where the
   // sender keeps offering so the input side stalls too.
   task automatic send_tick(input req_type tick);
      req_valid <= 1'b1;
      req_data  <= tick;
      do @(posedge clock); while (req_stall);
      tracker.note_tick(tick);
      if (gaps_on && !long_hold && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // Leaves the write enable high; the caller lowers it so back-to-back writes
   // stay clean.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      tracker.write_register(index, data);
   endtask

   // Registers change only with the pipeline empty. The upper data bits above
   // the alpha field carry junk, which the block must ignore.
   task automatic configure(input logic [COUNT_W-1:0] reload,
                            input logic [ALPHA_W-1:0] alpha);
      logic [CSR_DATA_W-ALPHA_W-1:0] junk;
      junk = (CSR_DATA_W-ALPHA_W)'($urandom_range(0, 127));
      while (tracker.pending() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      write_register(CSR_AUTO_RELOAD, reload);
      write_register(CSR_FILTER_ALPHA, {junk, alpha});
      csr_write <= 1'b0;
      cur_period = longint'(reload) + 1;
      enc_pos = enc_pos % cur_period;
   endtask

   // Mostly a plausible shaft motion: steps of mixed size that wrap modulo the
   // counter period, with the direction bit matching the motion and flipping now
   // and then. One tick in five is noise with a random count and direction.
   task automatic run_phase(input int count, input int hold_at, input bit allow_gaps);
      req_type tick;
      longint  mag;
      longint  half;
      int      sel;
      half = cur_period / 2;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
         if (i == hold_at) long_hold = 1'b1;
         if ($urandom_range(0, 4) == 0) begin
            tick.counter_value = COUNT_W'($urandom_range(0, 65535));
            tick.count_down    = 1'($urandom_range(0, 1));
            enc_pos = longint'(tick.counter_value) % cur_period;
         end else begin
            sel = $urandom_range(0, 9);
            if (sel < 5) mag = $urandom_range(0, 16);
            else if (sel < 8) mag = $urandom_range(0, 600);
            else mag = $urandom_range(0, 32767);
            if (mag > half) mag = half;
            if ($urandom_range(0, 15) == 0) moving_down = !moving_down;
            enc_pos = moving_down ? enc_pos - mag : enc_pos + mag;
            enc_pos = ((enc_pos % cur_period) + cur_period) % cur_period;
            tick.counter_value = enc_pos[COUNT_W-1:0];
            tick.count_down    = moving_down;
         end
         send_tick(tick);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks under the reset register values.
      for (int i = 0; i < 16; i++) begin
         send_tick(req_type'(DIRECTED_TICKS[i]));
      end
      req_valid <= 1'b0;

      // Register extremes first: alpha at zero, the shortest counter periods,
      // alpha at one and above one, and a counter that cannot move at all.
      configure(16'hFFFF, 9'd0);
      run_phase(250, -1, 1'b1);
      configure(16'd1, ALPHA_ONE);
      run_phase(200, -1, 1'b1);
      configure(16'd1023, 9'd511);
      run_phase(250, -1, 1'b1);
      configure(16'd0, 9'd300);
      run_phase(100, -1, 1'b1);

      // Random settings; this phase includes the long output hold.
      configure(COUNT_W'($urandom_range(2, 65535)), ALPHA_W'($urandom_range(0, 511)));
      run_phase(250, 60, 1'b1);
      configure(COUNT_W'($urandom_range(100, 5000)), ALPHA_W'($urandom_range(0, 511)));
      run_phase(250, -1, 1'b1);

      // Back to the reset values, at full rate with no idling on either side.
      configure(AUTO_RELOAD_RESET, FILTER_ALPHA_RESET);
      run_phase(300, -1, 1'b0);

      while (tracker.pending() != 0) @(posedge clock);
      repeat (4 * LATENCY) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
